>>> design/quota_limit_table_assert.svh
// Assertion macros shared by the quota table modules
`ifndef QUOTA_LIMIT_TABLE_ASSERT_SVH
`define QUOTA_LIMIT_TABLE_ASSERT_SVH
// Implication checked at each clock edge outside reset
`define QLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define QLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/qlt_pkg.sv
// Shared types and constants of the quota limit table
package qlt_pkg;
  localparam int TableEntries = 256;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int InW = 232;
  localparam int OutW = 392;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_CHANGE = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  // Command passed from front to back
  typedef struct packed {
    mode_t       mode;
    logic        is_hard;
    logic        is_bytes;
    logic [63:0] value;
    logic        own_grp;
    logic [31:0] own_id;
    logic [31:0] uid;
    logic [31:0] gid;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;
endpackage

>>> design/qlt_front.sv
// Front part: unpack input items into commands and queue them
module qlt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [qlt_pkg::InW-1:0] in_tdata,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output qlt_pkg::cmd_t        cmd
);
  import qlt_pkg::*;

  // Two-entry queue of commands
  cmd_t     q_r [2];
  logic     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t     c_in;
  logic     push, pop;

  // Classify fields of the input word
  always_comb begin
    c_in.mode     = mode_t'(in_tdata[1:0]);
    c_in.own_grp  = in_tdata[2];
    c_in.own_id   = in_tdata[34:3];
    c_in.uid      = in_tdata[66:35];
    c_in.gid      = in_tdata[98:67];
    c_in.is_hard  = in_tdata[99];
    c_in.is_bytes = in_tdata[100];
    // set mode carries the limit, change mode the delta
    c_in.value    = (in_tdata[1:0] == MODE_CHANGE) ? in_tdata[228:165] : in_tdata[164:101];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c_in;
  end

  `include "quota_limit_table_assert.svh"
  `QLT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `QLT_ASSERT_NXT(a_push_only, push && !pop && cnt_r == 2'd1, cnt_r == 2'd2)
  `QLT_ASSERT_NXT(a_pop_only, pop && !push && cnt_r == 2'd1, cnt_r == 2'd0)
endmodule

>>> design/qlt_back.sv
// Back part: search the table, update records and form results
module qlt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  qlt_pkg::cmd_t         cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [qlt_pkg::OutW-1:0] out_tdata
);
  import qlt_pkg::*;

  // Table storage: used bits in flops, keys scanned one per cycle, records in memories
  logic [TableEntries-1:0] used_r;
  logic [32:0]             key_mem [TableEntries];
  // Per record from the low end: inodes soft, inodes hard, bytes soft, bytes hard
  logic [255:0]            lim_mem [TableEntries];
  // Per record from the low end: inodes used, bytes used
  logic [127:0]            use_mem [TableEntries];

  state_t state_r, state_nxt;
  cmd_t   c_r;
  logic [CntW-1:0] sidx_r, sidx_nxt;
  logic [CntW-1:0] nfree_r;
  logic            uf_r, gf_r, ff_r;
  logic [IdxW-1:0] us_r, gs_r, fs_r, fs2_r;
  logic            ff2_r;
  logic [32:0]     ku, kg, ko, kcur_r;
  logic            scan_last;
  logic [255:0]    rdl_r, grdl_r;
  logic [127:0]    rdu_r, grdu_r;
  logic [7:0]      lsel;
  logic [6:0]      usel;
  logic [OutW-1:0] obuf_r;
  logic            ovalid_r;
  logic            full_w;
  logic            ucreate, gcreate;
  logic [IdxW-1:0] uslot, gslot;

  assign ku = {1'b0, c_r.uid};
  assign kg = {1'b1, c_r.gid};
  assign ko = {c_r.own_grp, c_r.own_id};
  assign scan_last = (sidx_r == CntW'(TableEntries - 1));
  // Bit offsets of the selected limit and usage inside a record
  assign lsel = {c_r.is_bytes, c_r.is_hard, 6'd0};
  assign usel = {c_r.is_bytes, 6'd0};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: if (!ovalid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_ready = (state_r == ST_IDLE);
    sidx_nxt  = (state_r == ST_SCAN) ? sidx_r + 1'b1 : '0;
  end

  // Creation decisions
  always_comb begin
    ucreate = 1'b0;
    gcreate = 1'b0;
    uslot   = us_r;
    gslot   = gs_r;
    full_w  = 1'b0;
    case (c_r.mode)
      MODE_SET: begin
        if (!uf_r) begin
          if (ff_r) begin
            ucreate = 1'b1;
            uslot   = fs_r;
          end else begin
            full_w = 1'b1;
          end
        end
      end
      MODE_CHANGE: begin
        if ((CntW'(!uf_r) + CntW'(!gf_r)) > nfree_r) full_w = 1'b1;
        else begin
          ucreate = !uf_r;
          gcreate = !gf_r;
          if (!uf_r) uslot = fs_r;
          if (!gf_r) gslot = uf_r ? fs_r : fs2_r;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, used bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (state_r == ST_EXEC) begin
        ovalid_r <= 1'b1;
        if (ucreate) used_r[uslot] <= 1'b1;
        if (gcreate) used_r[gslot] <= 1'b1;
      end
    end
  end

  // Scan keys one slot a cycle; user/owner match, group match, free slots
  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    // fetch the key of the slot scanned next
    kcur_r <= key_mem[sidx_nxt[IdxW-1:0]];
    if (state_r == ST_IDLE && cmd_valid) begin
      c_r     <= cmd;
      uf_r    <= 1'b0;
      gf_r    <= 1'b0;
      ff_r    <= 1'b0;
      ff2_r   <= 1'b0;
      nfree_r <= '0;
    end
    if (state_r == ST_SCAN) begin
      if (used_r[sidx_r[IdxW-1:0]]) begin
        if (((c_r.mode == MODE_SET || c_r.mode == MODE_LOOKUP) && kcur_r == ko) ||
            ((c_r.mode == MODE_CHANGE || c_r.mode == MODE_CHECK) && kcur_r == ku)) begin
          uf_r <= 1'b1;
          us_r <= sidx_r[IdxW-1:0];
        end
        if (kcur_r == kg) begin
          gf_r <= 1'b1;
          gs_r <= sidx_r[IdxW-1:0];
        end
      end else begin
        nfree_r <= nfree_r + 1'b1;
        if (!ff_r) begin
          ff_r <= 1'b1;
          fs_r <= sidx_r[IdxW-1:0];
        end else if (!ff2_r) begin
          ff2_r <= 1'b1;
          fs2_r <= sidx_r[IdxW-1:0];
        end
      end
    end
  end

  // Read records of the matched slots
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rdl_r  <= lim_mem[us_r];
      rdu_r  <= use_mem[us_r];
      grdl_r <= lim_mem[gs_r];
      grdu_r <= use_mem[gs_r];
    end
  end

  // Write back records and form the result
  always_ff @(posedge clk) begin
    logic [63:0]     ul, uu, gl, gu;
    logic            ue, ge;
    logic [255:0]    nl;
    logic [127:0]    nu, ng;
    logic [OutW-1:0] ob;
    if (state_r == ST_EXEC) begin
      ul = rdl_r[lsel +: 64];
      uu = rdu_r[usel +: 64] + 64'(c_r.is_hard);
      gl = grdl_r[lsel +: 64];
      gu = grdu_r[usel +: 64] + 64'(c_r.is_hard);
      ue = uf_r && ul != '0 && uu > ul;
      ge = gf_r && gl != '0 && gu > gl;
      nl = ucreate ? '0 : rdl_r;
      nl[lsel +: 64] = c_r.value;
      nu = ucreate ? '0 : rdu_r;
      nu[usel +: 64] = nu[usel +: 64] + c_r.value;
      ng = gcreate ? '0 : grdu_r;
      ng[usel +: 64] = ng[usel +: 64] + c_r.value;
      if (ucreate) key_mem[uslot] <= (c_r.mode == MODE_SET) ? ko : ku;
      if (gcreate) key_mem[gslot] <= kg;
      if (!full_w) begin
        if (c_r.mode == MODE_SET) begin
          lim_mem[uslot] <= nl;
          if (ucreate) use_mem[uslot] <= '0;
        end else if (c_r.mode == MODE_CHANGE) begin
          if (ucreate) lim_mem[uslot] <= '0;
          if (gcreate) lim_mem[gslot] <= '0;
          use_mem[uslot] <= nu;
          use_mem[gslot] <= ng;
        end
      end
      ob = '0;
      if (c_r.mode == MODE_CHECK) ob[0] = ue || ge;
      if (c_r.mode == MODE_SET || c_r.mode == MODE_CHANGE) ob[1] = full_w;
      if (c_r.mode == MODE_LOOKUP && uf_r) ob = {rdu_r, rdl_r, 5'd0, 1'b1, 2'b00};
      obuf_r <= ob;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r;

  `include "quota_limit_table_assert.svh"
  `QLT_ASSERT_IMP(a_ready_idle, cmd_ready, !ovalid_r || state_r == ST_IDLE)
  `QLT_ASSERT_NXT(a_exec_valid, state_r == ST_EXEC, ovalid_r)
  `QLT_ASSERT_IMP(a_scan_bound, state_r == ST_SCAN, sidx_r < CntW'(TableEntries))
endmodule

>>> design/quota_limit_table.sv
// Quota limit table: 256-record associative table of quota records.
// An input passes the two-entry front queue; the back part scans all slots, reads the
// matched records and registers the result, starting no new command before it is taken.
// The key scan, one slot per cycle, serves the owner/user, group and free-slot searches.
// Reset (rst_n low, synchronous): all records freed, queue and output emptied.
module quota_limit_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // mode, owner_is_group, owner_id, user_id, group_id, is_hard, is_bytes,
  // limit_value, usage_delta (zero padded)
  input  logic [qlt_pkg::InW-1:0]   in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // exceeded, table_full, found, pad 5, inodes_soft_limit, inodes_hard_limit,
  // bytes_soft_limit, bytes_hard_limit, inodes_used, bytes_used
  output logic [qlt_pkg::OutW-1:0]  out_tdata
);
  import qlt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  qlt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cmd_valid, .cmd_ready, .cmd
  );

  qlt_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

>>> tb/quota_limit_table_tb.sv
// Self-checking testbench for the quota limit table: stream driver, receiver and scoreboard
`timescale 1ns / 100ps

module quota_limit_table_tb;
  import qlt_pkg::*;

  localparam int Slots = TableEntries;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    mode_t       mode;
    bit          owner_is_group;
    bit [31:0]   owner_id;
    bit [31:0]   user_id;
    bit [31:0]   group_id;
    bit          is_hard;
    bit          is_bytes;
    bit [63:0]   limit_value;
    bit [63:0]   usage_delta;
  } quota_op_t;

  typedef struct {
    bit          exceeded;
    bit          table_full;
    bit          found;
    bit [63:0]   limits [4];
    bit [63:0]   used [2];
  } quota_res_t;

  // Mirror of the quota records and queue of expected responses
  class quota_scoreboard;
    bit         rec_used [Slots];
    bit [32:0]  rec_key [Slots];
    bit [63:0]  rec_limit [Slots][4];
    bit [63:0]  rec_usage [Slots][2];
    quota_res_t pending [$];
    int         errors;
    int         checked;
    int         n_full;
    int         n_exceeded;
    int         n_found;

    function int find_rec(bit [32:0] k);
      for (int i = 0; i < Slots; i++)
        if (rec_used[i] && rec_key[i] == k) return i;
      return -1;
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < Slots; i++)
        if (!rec_used[i]) n++;
      return n;
    endfunction

    // Take the lowest free slot, all fields zero
    function int create_rec(bit [32:0] k);
      for (int i = 0; i < Slots; i++)
        if (!rec_used[i]) begin
          rec_used[i] = 1'b1;
          rec_key[i] = k;
          for (int j = 0; j < 4; j++) rec_limit[i][j] = '0;
          rec_usage[i][0] = '0;
          rec_usage[i][1] = '0;
          return i;
        end
      return -1;
    endfunction

    function bit over_limit(bit [32:0] k, bit hard, bit bytes);
      int s;
      bit [63:0] lim;
      bit [63:0] u;
      s = find_rec(k);
      if (s < 0) return 1'b0;
      lim = rec_limit[s][{bytes, hard}];
      u = rec_usage[s][bytes];
      if (hard) u = u + 64'd1;
      return lim != 0 && u > lim;
    endfunction

    function void note_input(quota_op_t op);
      quota_res_t r;
      int s, su, sg, need;
      r.exceeded = 0;
      r.table_full = 0;
      r.found = 0;
      for (int j = 0; j < 4; j++) r.limits[j] = '0;
      r.used[0] = '0;
      r.used[1] = '0;
      case (op.mode)
        MODE_SET: begin
          s = find_rec({op.owner_is_group, op.owner_id});
          if (s < 0) s = create_rec({op.owner_is_group, op.owner_id});
          if (s < 0) r.table_full = 1;
          else rec_limit[s][{op.is_bytes, op.is_hard}] = op.limit_value;
        end
        MODE_CHANGE: begin
          su = find_rec({1'b0, op.user_id});
          sg = find_rec({1'b1, op.group_id});
          need = (su < 0) + (sg < 0);
          if (need > free_count()) r.table_full = 1;
          else begin
            if (su < 0) su = create_rec({1'b0, op.user_id});
            if (sg < 0) sg = create_rec({1'b1, op.group_id});
            rec_usage[su][op.is_bytes] += op.usage_delta;
            rec_usage[sg][op.is_bytes] += op.usage_delta;
          end
        end
        MODE_CHECK: begin
          r.exceeded = over_limit({1'b0, op.user_id}, op.is_hard, op.is_bytes) ||
                       over_limit({1'b1, op.group_id}, op.is_hard, op.is_bytes);
        end
        default: begin
          s = find_rec({op.owner_is_group, op.owner_id});
          if (s >= 0) begin
            r.found = 1;
            for (int j = 0; j < 4; j++) r.limits[j] = rec_limit[s][j];
            r.used[0] = rec_usage[s][0];
            r.used[1] = rec_usage[s][1];
          end
        end
      endcase
      n_full += r.table_full;
      n_exceeded += r.exceeded;
      n_found += r.found;
      pending = {pending, r};
    endfunction

    function void check_result(quota_res_t a);
      quota_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("response with no pending expectation");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.exceeded !== e.exceeded) begin
        $error("exceeded: expected %0d actual %0d", e.exceeded, a.exceeded);
        errors++;
      end
      if (a.table_full !== e.table_full) begin
        $error("table_full: expected %0d actual %0d", e.table_full, a.table_full);
        errors++;
      end
      if (a.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, a.found);
        errors++;
      end
      for (int j = 0; j < 4; j++)
        if (a.limits[j] !== e.limits[j]) begin
          $error("%s: expected %h actual %h",
                 j == 0 ? "inodes_soft_limit" : j == 1 ? "inodes_hard_limit" :
                 j == 2 ? "bytes_soft_limit" : "bytes_hard_limit",
                 e.limits[j], a.limits[j]);
          errors++;
        end
      if (a.used[0] !== e.used[0]) begin
        $error("inodes_used: expected %h actual %h", e.used[0], a.used[0]);
        errors++;
      end
      if (a.used[1] !== e.used[1]) begin
        $error("bytes_used: expected %h actual %h", e.used[1], a.used[1]);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  // mode, owner_is_group, owner_id, user_id, group_id, is_hard, is_bytes,
  // limit_value, usage_delta (zero padded)
  logic [InW-1:0]  in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  // exceeded, table_full, found, pad 5, inodes_soft_limit, inodes_hard_limit,
  // bytes_soft_limit, bytes_hard_limit, inodes_used, bytes_used
  logic [OutW-1:0] out_tdata;

  quota_scoreboard sb = new();
  int      send_idle_pct;
  int      recv_idle_pct;
  longint  cycles = 0;
  int      fresh_id;

  quota_limit_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("quota_limit_table_tb failed");
      $finish;
    end
  end

  // Check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    quota_res_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.exceeded = out_tdata[0];
      r.table_full = out_tdata[1];
      r.found = out_tdata[2];
      for (int j = 0; j < 4; j++) r.limits[j] = out_tdata[8 + 64*j +: 64];
      r.used[0] = out_tdata[264 +: 64];
      r.used[1] = out_tdata[328 +: 64];
      sb.check_result(r);
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one operation and hold it until the transfer
  task automatic send_op(quota_op_t op);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, op.usage_delta, op.limit_value, op.is_bytes, op.is_hard,
                 op.group_id, op.user_id, op.owner_id, op.owner_is_group, op.mode};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op);
  endtask

  task automatic send_fields(mode_t m, bit grp, bit [31:0] oid, bit [31:0] uid,
                             bit [31:0] gid, bit hard, bit bytes, bit [63:0] val,
                             bit [63:0] delta);
    quota_op_t op;
    op.mode = m; op.owner_is_group = grp; op.owner_id = oid;
    op.user_id = uid; op.group_id = gid; op.is_hard = hard; op.is_bytes = bytes;
    op.limit_value = val; op.usage_delta = delta;
    send_op(op);
  endtask

  function automatic bit [31:0] pick_id(bit fresh);
    if (fresh) begin
      fresh_id++;
      return 32'h1000 + fresh_id;
    end
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return $urandom_range(5);
    endcase
  endfunction

  function automatic bit [63:0] pick_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return {$urandom(), $urandom()};
      default: return $urandom_range(12);
    endcase
  endfunction

  function automatic bit [63:0] pick_delta();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return {$urandom(), $urandom()};
      3: return -64'($urandom_range(4));
      default: return $urandom_range(4);
    endcase
  endfunction

  task automatic send_random(int count, bit filling);
    quota_op_t op;
    bit fresh;
    for (int i = 0; i < count; i++) begin
      fresh = filling && $urandom_range(3) != 0;
      op.mode = mode_t'(filling && $urandom_range(1) ? $urandom_range(1) : $urandom_range(3));
      op.owner_is_group = $urandom_range(1);
      op.owner_id = pick_id(fresh);
      op.user_id = pick_id(fresh);
      op.group_id = pick_id(fresh);
      op.is_hard = $urandom_range(1);
      op.is_bytes = $urandom_range(1);
      op.limit_value = pick_value();
      op.usage_delta = pick_delta();
      send_op(op);
    end
  endtask

  initial begin
    fresh_id = 0;
    send_idle_pct = 8;
    recv_idle_pct = 54;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each limit, usage near the limits, zero limit, wrap, missing records
    send_fields(MODE_LOOKUP, 0, 7, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_CHECK, 0, 0, 7, 7, 1, 1, 0, 0);
    send_fields(MODE_SET, 0, 7, 0, 0, 0, 0, 64'd3, 0);
    send_fields(MODE_SET, 0, 7, 0, 0, 1, 0, 64'd3, 0);
    send_fields(MODE_SET, 1, 32'hFFFF_FFFF, 0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_fields(MODE_SET, 1, 32'hFFFF_FFFF, 0, 0, 1, 1, 64'd5, 0);
    send_fields(MODE_CHANGE, 0, 0, 7, 32'hFFFF_FFFF, 0, 0, 0, 64'd3);
    send_fields(MODE_CHECK, 0, 0, 7, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_fields(MODE_CHECK, 0, 0, 7, 32'hFFFF_FFFF, 1, 0, 0, 0);
    send_fields(MODE_CHANGE, 0, 0, 7, 32'hFFFF_FFFF, 0, 0, 0, 64'd1);
    send_fields(MODE_CHECK, 0, 0, 7, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_fields(MODE_SET, 0, 7, 0, 0, 0, 0, 64'd0, 0);
    send_fields(MODE_CHECK, 0, 0, 7, 0, 0, 0, 0, 0);
    send_fields(MODE_CHANGE, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(MODE_CHECK, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, 0);
    send_fields(MODE_CHANGE, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, 0, 64'h8000_0000_0000_0000);
    send_fields(MODE_LOOKUP, 0, 7, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_LOOKUP, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_LOOKUP, 1, 0, 0, 0, 0, 0, 0, 0);

    // Random: small id pool with each idling mix, then fill the table past full
    send_random(480, 0);
    send_idle_pct = 54;
    recv_idle_pct = 8;
    send_random(480, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(330, 1);
    send_random(210, 0);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $error("%0d expected responses never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d operations: %0d table-full, %0d exceeded, %0d found",
             sb.checked, sb.n_full, sb.n_exceeded, sb.n_found);
    $display("records in use at end: %0d of %0d", Slots - sb.free_count(), Slots);
    if (sb.errors == 0) begin
      $display("quota_limit_table_tb passed");
    end else begin
      $display("quota_limit_table_tb failed");
    end
    $finish;
  end
endmodule
